// ===== rtl/ctv_pkg.sv =====
// Package for the compact-trapezoid vertex generator.
// Holds the beat widths, the per-type corner coefficient table and the decode helpers.
// No dependencies; used by ctrapezoid_vertex_generator and its checker.
package ctv_pkg;

  localparam int TYPE_W  = 5;
  localparam int COORD_W = 32;
  localparam int EXT_W   = 31;
  localparam int COUNT_W = 3;
  localparam int COORDS  = 10;
  localparam int CORNERS = 4;
  localparam int IN_W    = 136;
  localparam int OUT_W   = 328;

  localparam logic [TYPE_W-1:0] NUM_TYPES   = 5'd26;
  localparam logic [TYPE_W-1:0] TYPE_YW_LO  = 5'd16;
  localparam logic [TYPE_W-1:0] TYPE_YW_HI  = 5'd19;
  localparam logic [TYPE_W-1:0] TYPE_XH2_LO = 5'd20;
  localparam logic [TYPE_W-1:0] TYPE_XH2_HI = 5'd21;
  localparam logic [TYPE_W-1:0] TYPE_YW2_LO = 5'd22;
  localparam logic [TYPE_W-1:0] TYPE_YW2_HI = 5'd23;

  localparam logic [COUNT_W-1:0] COUNT_NONE = 3'd0;
  localparam logic [COUNT_W-1:0] COUNT_TRI  = 3'd3;
  localparam logic [COUNT_W-1:0] COUNT_QUAD = 3'd4;

  typedef enum logic [1:0] {
    MUL_ZERO = 2'd0,
    MUL_ONE  = 2'd1,
    MUL_NEG  = 2'd2,
    MUL_TWO  = 2'd3
  } mult_t;

  typedef struct packed {
    logic  base_en;
    mult_t mw;
    mult_t mh;
  } coord_ctrl_t;

  typedef struct packed {
    logic [COUNT_W-1:0]             count;
    coord_ctrl_t [COORDS-1:0]       coord;
  } shape_ctrl_t;

  localparam mult_t C0 = MUL_ZERO;
  localparam mult_t CP = MUL_ONE;
  localparam mult_t CN = MUL_NEG;
  localparam mult_t C2 = MUL_TWO;

  // Per type and corner: x per w, x per h, y per w, y per h.
  localparam mult_t COEF_TAB [26][CORNERS][4] = '{
    '{'{C0,C0,C0,C0}, '{CP,C0,C0,C0}, '{CP,CN,C0,CP}, '{C0,C0,C0,CP}},
    '{'{C0,C0,C0,C0}, '{CP,CN,C0,C0}, '{CP,C0,C0,CP}, '{C0,C0,C0,CP}},
    '{'{C0,C0,C0,C0}, '{CP,C0,C0,C0}, '{CP,C0,C0,CP}, '{C0,CP,C0,CP}},
    '{'{C0,C0,C0,CP}, '{C0,CP,C0,C0}, '{CP,C0,C0,C0}, '{CP,C0,C0,CP}},
    '{'{C0,C0,C0,C0}, '{CP,C0,C0,C0}, '{CP,CN,C0,CP}, '{C0,CP,C0,CP}},
    '{'{C0,C0,C0,CP}, '{C0,CP,C0,C0}, '{CP,CN,C0,C0}, '{CP,C0,C0,CP}},
    '{'{C0,C0,C0,C0}, '{CP,CN,C0,C0}, '{CP,C0,C0,CP}, '{C0,CP,C0,CP}},
    '{'{C0,C0,C0,CP}, '{C0,CP,C0,C0}, '{CP,C0,C0,C0}, '{CP,CN,C0,CP}},
    '{'{C0,C0,C0,C0}, '{CP,C0,C0,C0}, '{CP,C0,CN,CP}, '{C0,C0,C0,CP}},
    '{'{C0,C0,C0,C0}, '{CP,C0,C0,C0}, '{CP,C0,C0,CP}, '{C0,C0,CP,C0}},
    '{'{C0,C0,C0,C0}, '{CP,C0,CP,C0}, '{CP,C0,C0,CP}, '{C0,C0,C0,CP}},
    '{'{C0,C0,CP,C0}, '{CP,C0,C0,C0}, '{CP,C0,C0,CP}, '{C0,C0,C0,CP}},
    '{'{C0,C0,C0,C0}, '{CP,C0,CP,C0}, '{CP,C0,CN,CP}, '{C0,C0,C0,CP}},
    '{'{C0,C0,CP,C0}, '{CP,C0,C0,C0}, '{CP,C0,C0,CP}, '{C0,C0,CN,CP}},
    '{'{C0,C0,C0,C0}, '{CP,C0,CP,C0}, '{CP,C0,C0,CP}, '{C0,C0,CN,CP}},
    '{'{C0,C0,CP,C0}, '{CP,C0,C0,C0}, '{CP,C0,CN,CP}, '{C0,C0,C0,CP}},
    '{'{C0,C0,C0,C0}, '{CP,C0,C0,C0}, '{C0,C0,CP,C0}, '{C0,C0,C0,C0}},
    '{'{C0,C0,C0,C0}, '{CP,C0,CP,C0}, '{C0,C0,CP,C0}, '{C0,C0,C0,C0}},
    '{'{C0,C0,C0,C0}, '{CP,C0,C0,C0}, '{CP,C0,CP,C0}, '{C0,C0,C0,C0}},
    '{'{C0,C0,CP,C0}, '{CP,C0,C0,C0}, '{CP,C0,CP,C0}, '{C0,C0,C0,C0}},
    '{'{C0,C0,C0,C0}, '{C0,C2,C0,C0}, '{C0,CP,C0,CP}, '{C0,C0,C0,C0}},
    '{'{C0,C0,C0,CP}, '{C0,CP,C0,C0}, '{C0,C2,C0,CP}, '{C0,C0,C0,C0}},
    '{'{C0,C0,C0,C0}, '{CP,C0,CP,C0}, '{C0,C0,C2,C0}, '{C0,C0,C0,C0}},
    '{'{C0,C0,CP,C0}, '{CP,C0,C0,C0}, '{CP,C0,C2,C0}, '{C0,C0,C0,C0}},
    '{'{C0,C0,C0,C0}, '{CP,C0,C0,C0}, '{CP,C0,C0,CP}, '{C0,C0,C0,CP}},
    '{'{C0,C0,C0,C0}, '{CP,C0,C0,C0}, '{CP,C0,CP,C0}, '{C0,C0,CP,C0}}
  };

  // Coordinates 0..7 are the corners (x then y), 8 is max_x and 9 is max_y.
  function automatic shape_ctrl_t decode(input logic [TYPE_W-1:0] t);
    shape_ctrl_t c;
    int          k;
    c = '0;
    if (t < NUM_TYPES) begin
      c.count = (t >= TYPE_YW_LO && t <= TYPE_YW2_HI) ? COUNT_TRI : COUNT_QUAD;
      for (k = 0; k < CORNERS; k++) begin
        if (k < int'(c.count)) begin
          c.coord[2*k]   = '{base_en: 1'b1, mw: COEF_TAB[t][k][0], mh: COEF_TAB[t][k][1]};
          c.coord[2*k+1] = '{base_en: 1'b1, mw: COEF_TAB[t][k][2], mh: COEF_TAB[t][k][3]};
        end
      end
    end
    if (t == TYPE_XH2_LO || t == TYPE_XH2_HI) begin
      c.coord[8] = '{base_en: 1'b1, mw: MUL_ZERO, mh: MUL_TWO};
    end else begin
      c.coord[8] = '{base_en: 1'b1, mw: MUL_ONE, mh: MUL_ZERO};
    end
    if (t >= TYPE_YW_LO && t <= TYPE_YW_HI) begin
      c.coord[9] = '{base_en: 1'b1, mw: MUL_ONE, mh: MUL_ZERO};
    end else if (t == TYPE_YW2_LO || t == TYPE_YW2_HI) begin
      c.coord[9] = '{base_en: 1'b1, mw: MUL_TWO, mh: MUL_ZERO};
    end else begin
      c.coord[9] = '{base_en: 1'b1, mw: MUL_ZERO, mh: MUL_ONE};
    end
    return c;
  endfunction

  function automatic logic [COORD_W-1:0] scale(input mult_t m, input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] r;
    case (m)
      MUL_ZERO: r = '0;
      MUL_ONE:  r = v;
      MUL_NEG:  r = (~v) + 32'd1;
      MUL_TWO:  r = {v[COORD_W-2:0], 1'b0};
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ctrapezoid_vertex_generator.sv =====
// Throughput: one shape per cycle unless the output stalls; the three register stages
// are the type decode, the origin plus width term, and the height term into the output
// register.
// Each stage loads when it is empty or its successor moves, so bubbles are absorbed.
// Reset is synchronous and active high; it clears the stage valid bits only.
// Depends on ctv_pkg.
module ctrapezoid_vertex_generator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // shape_type, origin_x, origin_y, shape_width, shape_height, zero pad.
  input  logic [ctv_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // vertex_count, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, v3_x, v3_y, max_x, max_y, zero pad.
  output logic [ctv_pkg::OUT_W-1:0] m_axis_tdata
);

  logic                                               a_valid;
  ctv_pkg::shape_ctrl_t                               a_ctrl;
  logic [ctv_pkg::COORD_W-1:0]                        a_x;
  logic [ctv_pkg::COORD_W-1:0]                        a_y;
  logic [ctv_pkg::COORD_W-1:0]                        a_w;
  logic [ctv_pkg::COORD_W-1:0]                        a_h;

  logic                                               b_valid;
  logic [ctv_pkg::COUNT_W-1:0]                        b_count;
  logic [ctv_pkg::COORDS-1:0][ctv_pkg::COORD_W-1:0]   b_part;
  logic [ctv_pkg::COORDS-1:0][ctv_pkg::COORD_W-1:0]   b_hterm;
  logic [ctv_pkg::COORDS-1:0][ctv_pkg::COORD_W-1:0]   b_part_next;
  logic [ctv_pkg::COORDS-1:0][ctv_pkg::COORD_W-1:0]   b_hterm_next;

  logic                                               c_valid;
  logic [ctv_pkg::COUNT_W-1:0]                        c_count;
  logic [ctv_pkg::COORDS-1:0][ctv_pkg::COORD_W-1:0]   c_coord;

  logic a_ready;
  logic b_ready;
  logic c_ready;

  assign c_ready       = !c_valid || m_axis_tready;
  assign b_ready       = !b_valid || c_ready;
  assign a_ready       = !a_valid || b_ready;
  assign s_axis_tready = a_ready;

  always_comb begin
    for (int i = 0; i < ctv_pkg::COORDS; i++) begin
      logic [ctv_pkg::COORD_W-1:0] base;
      base = (i % 2 == 0) ? a_x : a_y;
      if (!a_ctrl.coord[i].base_en) begin
        base = '0;
      end
      b_part_next[i]  = base + ctv_pkg::scale(a_ctrl.coord[i].mw, a_w);
      b_hterm_next[i] = ctv_pkg::scale(a_ctrl.coord[i].mh, a_h);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= s_axis_tvalid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && s_axis_tvalid) begin
      a_ctrl <= ctv_pkg::decode(s_axis_tdata[4:0]);
      a_x    <= s_axis_tdata[36:5];
      a_y    <= s_axis_tdata[68:37];
      a_w    <= {1'b0, s_axis_tdata[99:69]};
      a_h    <= {1'b0, s_axis_tdata[130:100]};
    end
    if (b_ready && a_valid) begin
      b_count <= a_ctrl.count;
      b_part  <= b_part_next;
      b_hterm <= b_hterm_next;
    end
    if (c_ready && b_valid) begin
      c_count <= b_count;
      for (int i = 0; i < ctv_pkg::COORDS; i++) begin
        c_coord[i] <= b_part[i] + b_hterm[i];
      end
    end
  end

  assign m_axis_tvalid = c_valid;
  assign m_axis_tdata  = {5'd0, c_coord, c_count};

endmodule

// ===== rtl/ctv_checker.sv =====
// Port-level checker for ctrapezoid_vertex_generator, with its bind statement.
// Depends on ctv_pkg for the beat widths.
module ctv_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [ctv_pkg::OUT_W-1:0] m_axis_tdata
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Output beat valid right after reset.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled output beat changed.");

  a_tri_no_fourth: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] == ctv_pkg::COUNT_TRI |->
    m_axis_tdata[258:195] == 64'd0)
    else $error("Three-corner shape carries a fourth corner.");

  a_none_no_vertex: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] == ctv_pkg::COUNT_NONE |->
    m_axis_tdata[258:3] == 256'd0)
    else $error("Unknown shape type carries vertices.");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("Input stalled while the output beat can move.");

endmodule

bind ctrapezoid_vertex_generator ctv_checker u_ctv_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/tb.sv =====
// Self-checking testbench for ctrapezoid_vertex_generator: shapes stream in, vertex beats stream out.
// A scoreboard class predicts each shape's corners and maxima and checks the beats in order.
// Depends on ctv_pkg and the ctrapezoid_vertex_generator RTL.
`timescale 1ns / 100ps

module tb;

  typedef logic [ctv_pkg::TYPE_W-1:0] type_code_t;
  typedef logic [ctv_pkg::EXT_W-1:0]  extent_t;

  localparam type_code_t TYPE_LAST = '1;

  // Per type and corner: x per width, x per height, y per width, y per height.
  localparam int CORNER_MUL [26][4][4] = '{
    '{'{0,0,0,0}, '{1,0,0,0}, '{1,-1,0,1}, '{0,0,0,1}},
    '{'{0,0,0,0}, '{1,-1,0,0}, '{1,0,0,1}, '{0,0,0,1}},
    '{'{0,0,0,0}, '{1,0,0,0}, '{1,0,0,1}, '{0,1,0,1}},
    '{'{0,0,0,1}, '{0,1,0,0}, '{1,0,0,0}, '{1,0,0,1}},
    '{'{0,0,0,0}, '{1,0,0,0}, '{1,-1,0,1}, '{0,1,0,1}},
    '{'{0,0,0,1}, '{0,1,0,0}, '{1,-1,0,0}, '{1,0,0,1}},
    '{'{0,0,0,0}, '{1,-1,0,0}, '{1,0,0,1}, '{0,1,0,1}},
    '{'{0,0,0,1}, '{0,1,0,0}, '{1,0,0,0}, '{1,-1,0,1}},
    '{'{0,0,0,0}, '{1,0,0,0}, '{1,0,-1,1}, '{0,0,0,1}},
    '{'{0,0,0,0}, '{1,0,0,0}, '{1,0,0,1}, '{0,0,1,0}},
    '{'{0,0,0,0}, '{1,0,1,0}, '{1,0,0,1}, '{0,0,0,1}},
    '{'{0,0,1,0}, '{1,0,0,0}, '{1,0,0,1}, '{0,0,0,1}},
    '{'{0,0,0,0}, '{1,0,1,0}, '{1,0,-1,1}, '{0,0,0,1}},
    '{'{0,0,1,0}, '{1,0,0,0}, '{1,0,0,1}, '{0,0,-1,1}},
    '{'{0,0,0,0}, '{1,0,1,0}, '{1,0,0,1}, '{0,0,-1,1}},
    '{'{0,0,1,0}, '{1,0,0,0}, '{1,0,-1,1}, '{0,0,0,1}},
    '{'{0,0,0,0}, '{1,0,0,0}, '{0,0,1,0}, '{0,0,0,0}},
    '{'{0,0,0,0}, '{1,0,1,0}, '{0,0,1,0}, '{0,0,0,0}},
    '{'{0,0,0,0}, '{1,0,0,0}, '{1,0,1,0}, '{0,0,0,0}},
    '{'{0,0,1,0}, '{1,0,0,0}, '{1,0,1,0}, '{0,0,0,0}},
    '{'{0,0,0,0}, '{0,2,0,0}, '{0,1,0,1}, '{0,0,0,0}},
    '{'{0,0,0,1}, '{0,1,0,0}, '{0,2,0,1}, '{0,0,0,0}},
    '{'{0,0,0,0}, '{1,0,1,0}, '{0,0,2,0}, '{0,0,0,0}},
    '{'{0,0,1,0}, '{1,0,0,0}, '{1,0,2,0}, '{0,0,0,0}},
    '{'{0,0,0,0}, '{1,0,0,0}, '{1,0,0,1}, '{0,0,0,1}},
    '{'{0,0,0,0}, '{1,0,0,0}, '{1,0,1,0}, '{0,0,1,0}}
  };

  localparam logic [31:0] EDGE_WORD [6] = '{
    32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h4000_0001
  };

  typedef struct {
    type_code_t                  stype;
    logic [ctv_pkg::COORD_W-1:0] ox;
    logic [ctv_pkg::COORD_W-1:0] oy;
    extent_t                     w;
    extent_t                     h;
  } shape_t;

  typedef struct {
    logic [ctv_pkg::COUNT_W-1:0]      count;
    logic [7:0][ctv_pkg::COORD_W-1:0] corner;
    logic [ctv_pkg::COORD_W-1:0]      max_x;
    logic [ctv_pkg::COORD_W-1:0]      max_y;
  } vertices_t;

  class vertex_scoreboard;
    vertices_t expected_q[$];
    int        errors;
    int        beats;

    function new();
      errors = 0;
      beats  = 0;
    endfunction

    function logic [31:0] offset(input logic [31:0] base, input int cw,
                                 input int ch, input logic [31:0] w,
                                 input logic [31:0] h);
      offset = base + w * 32'(cw) + h * 32'(ch);
    endfunction

    function vertices_t predict_vertices(input shape_t s);
      vertices_t   r;
      logic [31:0] w;
      logic [31:0] h;
      int          k;
      w        = {1'b0, s.w};
      h        = {1'b0, s.h};
      r.count  = ctv_pkg::COUNT_NONE;
      r.corner = '0;
      if (s.stype < ctv_pkg::NUM_TYPES) begin
        r.count = (s.stype >= ctv_pkg::TYPE_YW_LO && s.stype <= ctv_pkg::TYPE_YW2_HI) ?
                  ctv_pkg::COUNT_TRI : ctv_pkg::COUNT_QUAD;
        for (k = 0; k < int'(r.count); k++) begin
          r.corner[2*k]   = offset(s.ox, CORNER_MUL[s.stype][k][0],
                                   CORNER_MUL[s.stype][k][1], w, h);
          r.corner[2*k+1] = offset(s.oy, CORNER_MUL[s.stype][k][2],
                                   CORNER_MUL[s.stype][k][3], w, h);
        end
      end
      if (s.stype == ctv_pkg::TYPE_XH2_LO || s.stype == ctv_pkg::TYPE_XH2_HI) begin
        r.max_x = s.ox + (h << 1);
      end else begin
        r.max_x = s.ox + w;
      end
      if (s.stype >= ctv_pkg::TYPE_YW_LO && s.stype <= ctv_pkg::TYPE_YW_HI) begin
        r.max_y = s.oy + w;
      end else if (s.stype == ctv_pkg::TYPE_YW2_LO || s.stype == ctv_pkg::TYPE_YW2_HI) begin
        r.max_y = s.oy + (w << 1);
      end else begin
        r.max_y = s.oy + h;
      end
      return r;
    endfunction

    task report_mismatch(input string what);
      $display("MISMATCH at output beat %0d: %s", beats, what);
      errors++;
    endtask

    function void note_shape(input shape_t s);
      expected_q.insert(expected_q.size(), predict_vertices(s));
    endfunction

    task check_vertices(input vertices_t got);
      vertices_t exp_v;
      int        k;
      beats++;
      if (expected_q.size() == 0) begin
        report_mismatch("output beat with no shape outstanding");
      end else begin
        exp_v = expected_q.pop_front();
        if (got.count !== exp_v.count)
          report_mismatch($sformatf("vertex_count %0d, expected %0d", got.count, exp_v.count));
        for (k = 0; k < 8; k++) begin
          if (got.corner[k] !== exp_v.corner[k])
            report_mismatch($sformatf("v%0d_%s %h, expected %h", k / 2,
                                      (k % 2) ? "y" : "x", got.corner[k], exp_v.corner[k]));
        end
        if (got.max_x !== exp_v.max_x)
          report_mismatch($sformatf("max_x %h, expected %h", got.max_x, exp_v.max_x));
        if (got.max_y !== exp_v.max_y)
          report_mismatch($sformatf("max_y %h, expected %h", got.max_y, exp_v.max_y));
      end
    endtask
  endclass

  logic                      clk;
  logic                      rst;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [ctv_pkg::IN_W-1:0]  s_axis_tdata;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [ctv_pkg::OUT_W-1:0] m_axis_tdata;

  vertex_scoreboard sb;
  int               tx_idle_pct;
  int               rx_stall_pct;
  logic             hold_on;

  ctrapezoid_vertex_generator uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [ctv_pkg::IN_W-1:0] pack_shape(input shape_t s);
    return {5'b0, s.h, s.w, s.oy, s.ox, s.stype};
  endfunction

  function automatic vertices_t unpack_vertices(input logic [ctv_pkg::OUT_W-1:0] d);
    vertices_t r;
    int        k;
    r.count = d[ctv_pkg::COUNT_W-1:0];
    for (k = 0; k < 8; k++) begin
      r.corner[k] = d[ctv_pkg::COUNT_W + ctv_pkg::COORD_W*k +: ctv_pkg::COORD_W];
    end
    r.max_x = d[ctv_pkg::COUNT_W + ctv_pkg::COORD_W*8 +: ctv_pkg::COORD_W];
    r.max_y = d[ctv_pkg::COUNT_W + ctv_pkg::COORD_W*9 +: ctv_pkg::COORD_W];
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return EDGE_WORD[0];
      1:       return EDGE_WORD[1];
      2:       return EDGE_WORD[2];
      3:       return EDGE_WORD[3];
      4:       return 32'($urandom_range(255));
      5:       return -32'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  function automatic shape_t random_shape();
    shape_t s;
    if ($urandom_range(9) == 0) begin
      s.stype = type_code_t'($urandom_range(int'(TYPE_LAST), int'(ctv_pkg::NUM_TYPES)));
    end else begin
      s.stype = type_code_t'($urandom_range(int'(ctv_pkg::NUM_TYPES) - 1));
    end
    s.ox = pick_word();
    s.oy = pick_word();
    s.w  = extent_t'(pick_word());
    s.h  = extent_t'(pick_word());
    return s;
  endfunction

  task automatic send_shape(input shape_t s);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_shape(s);
    do @(posedge clk); while (!s_axis_tready);
    sb.note_shape(s);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_vertices(unpack_vertices(m_axis_tdata));
    end
    m_axis_tready <= !hold_on && ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    shape_t s;
    int     i;
    int     phase;
    sb            = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    hold_on       = 1'b0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Every type plus two undefined codes, with the origin and extents at their edges.
    for (i = 0; i < int'(ctv_pkg::NUM_TYPES) + 2; i++) begin
      if (i < int'(ctv_pkg::NUM_TYPES)) s.stype = type_code_t'(i);
      else if (i == int'(ctv_pkg::NUM_TYPES)) s.stype = ctv_pkg::NUM_TYPES;
      else s.stype = TYPE_LAST;
      s.ox = EDGE_WORD[i % 6];
      s.oy = EDGE_WORD[(i + 2) % 6];
      s.w  = extent_t'(EDGE_WORD[(i + 1) % 6]);
      s.h  = extent_t'(EDGE_WORD[(i + 3) % 6]);
      send_shape(s);
    end

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 78; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 78; end
        default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
      endcase
      if (phase == 0) begin
        fork
          begin
            repeat (20) @(posedge clk);
            hold_on <= 1'b1;
            repeat (200) @(posedge clk);
            hold_on <= 1'b0;
          end
        join_none
      end
      repeat (270) send_shape(random_shape());
    end
    s_axis_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
